### src/triangle_face_normal_top_macros.svh
// Assertion macros used by the port checker
`ifndef TRIANGLE_FACE_NORMAL_TOP_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_TOP_MACROS_SVH

// same-cycle implication
`define TFN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tfn_pkg.sv
// Constants and types of the triangle face normal block
`timescale 1ns / 1ps
package tfn_pkg;
   localparam int VERTEX_DEPTH     = 4096;
   localparam int COORD_BITS       = 20;
   localparam int NORMAL_FRAC_BITS = 14;

   localparam int INDEX_BITS = 12;
   localparam int FIELD_BITS = 20;
   localparam int OUT_BITS   = 16;
   localparam int ADDR_BITS  = $clog2(VERTEX_DEPTH);
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * EDGE_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS   = PROD_BITS;
   localparam int M_BITS     = 31;
   localparam int SQ_BITS    = 2 * M_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;
   localparam int ROOT_BITS  = SUM_BITS / 2;
   localparam int QUO_BITS   = NORMAL_FRAC_BITS + 1;
   localparam int NUM_BITS   = M_BITS + NORMAL_FRAC_BITS + 1;
   localparam int SHIFT_BITS = $clog2(MAG_BITS + 1);
   localparam int OUT_MAX    = 2 ** (OUT_BITS - 1) - 1;
   localparam int OUT_MIN_MAG = 2 ** (OUT_BITS - 1);

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_FACE  = 1'b1;

   typedef struct packed {
      logic                         mode;
      logic [INDEX_BITS-1:0]        vertex_index;
      logic signed [FIELD_BITS-1:0] coord_x;
      logic signed [FIELD_BITS-1:0] coord_y;
      logic signed [FIELD_BITS-1:0] coord_z;
      logic [INDEX_BITS-1:0]        corner_a;
      logic [INDEX_BITS-1:0]        corner_b;
      logic [INDEX_BITS-1:0]        corner_c;
      logic                         last_face;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] normal_x;
      logic signed [OUT_BITS-1:0] normal_y;
      logic signed [OUT_BITS-1:0] normal_z;
      logic                       degenerate;
      logic                       final_mark;
   } rsp_payload_type;

   typedef struct packed {
      logic                   last;
      logic                   degen;
      logic [2:0]             neg;
      logic [2:0][M_BITS-1:0] m;
   } sqrt_side_type;

   typedef struct packed {
      logic       last;
      logic       degen;
      logic [2:0] neg;
   } div_side_type;
endpackage

### src/tfn_if.sv
// Valid/ready channels of the triangle face normal block
`timescale 1ns / 1ps
interface tfn_req_if;
   import tfn_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tfn_rsp_if;
   import tfn_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/tfn_sqrt.sv
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module tfn_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  logic [tfn_pkg::SUM_BITS-1:0]     in_rad,
   input  tfn_pkg::sqrt_side_type           in_side,
   output logic                             out_valid,
   output logic [tfn_pkg::ROOT_BITS-1:0]    out_root,
   output tfn_pkg::sqrt_side_type           out_side
);
   import tfn_pkg::*;

   logic                valid_ff [ROOT_BITS];
   logic [SUM_BITS-1:0] rem_ff   [ROOT_BITS];
   logic [SUM_BITS-1:0] res_ff   [ROOT_BITS];
   sqrt_side_type       side_ff  [ROOT_BITS];

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
      localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * i);
      logic                v_prev;
      logic [SUM_BITS-1:0] rem_prev, res_prev, trial, rem_in, res_in;
      sqrt_side_type       side_prev;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = in_rad;
         assign res_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign res_prev  = res_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign trial = res_prev + BIT;

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= v_prev;
         end
         if (enable) begin
            rem_ff[i]  <= rem_in;
            res_ff[i]  <= res_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = ROOT_BITS'(res_ff[ROOT_BITS-1]);
   assign out_side  = side_ff[ROOT_BITS-1];
endmodule

### src/tfn_div.sv
// Pipelined restoring divider for three numerators over one divisor
`timescale 1ns / 1ps
module tfn_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 in_valid,
   input  logic [tfn_pkg::ROOT_BITS-1:0]        in_divisor,
   input  logic [2:0][tfn_pkg::NUM_BITS-1:0]    in_num,
   input  tfn_pkg::div_side_type                in_side,
   output logic                                 out_valid,
   output logic [2:0][tfn_pkg::QUO_BITS-1:0]    out_quo,
   output tfn_pkg::div_side_type                out_side
);
   import tfn_pkg::*;

   logic                         valid_ff [QUO_BITS];
   logic [ROOT_BITS-1:0]         dvs_ff   [QUO_BITS];
   logic [2:0][NUM_BITS-1:0]     rem_ff   [QUO_BITS];
   logic [2:0][QUO_BITS-1:0]     quo_ff   [QUO_BITS];
   div_side_type                 side_ff  [QUO_BITS];

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
      localparam int K = QUO_BITS - 1 - j;
      logic                     v_prev;
      logic [ROOT_BITS-1:0]     dvs_prev;
      logic [2:0][NUM_BITS-1:0] rem_prev, rem_in;
      logic [2:0][QUO_BITS-1:0] quo_prev, quo_in;
      logic [NUM_BITS:0]        dsh;
      div_side_type             side_prev;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign dvs_prev  = in_divisor;
         assign rem_prev  = in_num;
         assign quo_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[j-1];
         assign dvs_prev  = dvs_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      assign dsh = (NUM_BITS + 1)'(dvs_prev) << K;

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            if ({1'b0, rem_prev[c]} >= dsh) begin
               rem_in[c] = rem_prev[c] - NUM_BITS'(dsh);
               quo_in[c] = quo_prev[c] | (QUO_BITS'(1) << K);
            end else begin
               rem_in[c] = rem_prev[c];
               quo_in[c] = quo_prev[c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= v_prev;
         end
         if (enable) begin
            dvs_ff[j]  <= dvs_prev;
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_BITS-1];
   assign out_quo   = quo_ff[QUO_BITS-1];
   assign out_side  = side_ff[QUO_BITS-1];
endmodule

### src/triangle_face_normal_top.sv
// Top level of the triangle face normal block
//
// Mode-0 words write one vertex into the store; mode-1 words read three
// corners and return the unit normal of that face in signed Q1.14. One word
// is accepted every cycle while the result port is not stalled. A face
// result passes through the vertex read, cross product and scaling
// registers, the one-bit-per-stage square root (32 stages), the
// one-bit-per-stage divider (15 stages) and the output register. The vertex
// store is kept in three copies so the three corners read in the same cycle.
// A vertex must be written before a face uses it; a face may name a vertex
// written by the word just before it. A stalled result port holds the whole
// pipeline and the input with it.
`timescale 1ns / 1ps
module triangle_face_normal_top (
   input logic      clock,
   input logic      reset,
   tfn_req_if.sink  req_chan,
   tfn_rsp_if.source rsp_chan
);
   import tfn_pkg::*;

   localparam int VTX_BITS = 3 * COORD_BITS;

   logic enable, accept;
   req_payload_type rq;

   logic [VTX_BITS-1:0] mem_a [VERTEX_DEPTH];
   logic [VTX_BITS-1:0] mem_b [VERTEX_DEPTH];
   logic [VTX_BITS-1:0] mem_c [VERTEX_DEPTH];

   logic                v1_ff, last1_ff;
   logic [2:0]          ok1_ff;
   logic [VTX_BITS-1:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic                wr_ok;
   logic [VTX_BITS-1:0] wr_word;

   logic signed [EDGE_BITS-1:0]  va [3], vb [3], vc [3];
   logic                         v2_ff, last2_ff;
   logic signed [EDGE_BITS-1:0]  u_ff [3], w_ff [3];

   logic                         v3_ff, last3_ff;
   logic signed [PROD_BITS-1:0]  p_ff [6];

   logic                         v4_ff, last4_ff;
   logic signed [CROSS_BITS-1:0] n_ff [3];

   logic                         v5_ff, last5_ff;
   logic [2:0]                   neg5_ff;
   logic [MAG_BITS-1:0]          mag5_ff [3];

   logic                         v6_ff, last6_ff, degen6_ff;
   logic [2:0]                   neg6_ff;
   logic [MAG_BITS-1:0]          mag6_ff [3];
   logic [SHIFT_BITS-1:0]        shift6_ff, shift_in;
   logic [MAG_BITS-1:0]          or_mag;

   logic                         v7_ff, last7_ff, degen7_ff;
   logic [2:0]                   neg7_ff;
   logic [2:0][M_BITS-1:0]       m7_ff;

   logic                         v8_ff, last8_ff, degen8_ff;
   logic [2:0]                   neg8_ff;
   logic [2:0][M_BITS-1:0]       m8_ff;
   logic [SQ_BITS-1:0]           sq8_ff [3];

   logic                         v9_ff;
   logic [SUM_BITS-1:0]          sum9_ff;
   sqrt_side_type                side9_ff;

   logic                         sq_valid;
   logic [ROOT_BITS-1:0]         sq_root;
   sqrt_side_type                sq_side;
   logic [2:0][NUM_BITS-1:0]     num;
   div_side_type                 dv_side_in, dv_side;
   logic                         dv_valid;
   logic [2:0][QUO_BITS-1:0]     dv_quo;

   logic                         rsp_valid_ff;
   rsp_payload_type              rsp_ff, rsp_in;
   logic signed [OUT_BITS-1:0]   comp [3];

   assign rq     = req_chan.payload;
   assign enable = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && enable;
   assign req_chan.ready = enable;

   assign wr_ok   = 32'(rq.vertex_index) < 32'(VERTEX_DEPTH);
   assign wr_word = {COORD_BITS'(rq.coord_z), COORD_BITS'(rq.coord_y),
                     COORD_BITS'(rq.coord_x)};

   // vertex store, three copies
   always_ff @(posedge clock) begin
      if (accept && rq.mode == MODE_WRITE && wr_ok) begin
         mem_a[ADDR_BITS'(rq.vertex_index)] <= wr_word;
         mem_b[ADDR_BITS'(rq.vertex_index)] <= wr_word;
         mem_c[ADDR_BITS'(rq.vertex_index)] <= wr_word;
      end
      if (enable) begin
         rd_a_ff <= mem_a[ADDR_BITS'(rq.corner_a)];
         rd_b_ff <= mem_b[ADDR_BITS'(rq.corner_b)];
         rd_c_ff <= mem_c[ADDR_BITS'(rq.corner_c)];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         va[i] = ok1_ff[0] ? EDGE_BITS'($signed(rd_a_ff[i*COORD_BITS +: COORD_BITS])) : '0;
         vb[i] = ok1_ff[1] ? EDGE_BITS'($signed(rd_b_ff[i*COORD_BITS +: COORD_BITS])) : '0;
         vc[i] = ok1_ff[2] ? EDGE_BITS'($signed(rd_c_ff[i*COORD_BITS +: COORD_BITS])) : '0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAG_BITS; i++) begin
         or_mag[i] = mag5_ff[0][i] | mag5_ff[1][i] | mag5_ff[2][i];
      end
      shift_in = '0;
      for (int k = M_BITS; k < MAG_BITS; k++) begin
         if (or_mag[k]) begin
            shift_in = SHIFT_BITS'(k - M_BITS + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= accept && rq.mode == MODE_FACE;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         last1_ff  <= rq.last_face;
         ok1_ff[0] <= 32'(rq.corner_a) < 32'(VERTEX_DEPTH);
         ok1_ff[1] <= 32'(rq.corner_b) < 32'(VERTEX_DEPTH);
         ok1_ff[2] <= 32'(rq.corner_c) < 32'(VERTEX_DEPTH);

         last2_ff <= last1_ff;
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= vb[i] - va[i];
            w_ff[i] <= vc[i] - va[i];
         end

         last3_ff <= last2_ff;
         p_ff[0] <= PROD_BITS'(u_ff[1] * w_ff[2]);
         p_ff[1] <= PROD_BITS'(u_ff[2] * w_ff[1]);
         p_ff[2] <= PROD_BITS'(u_ff[2] * w_ff[0]);
         p_ff[3] <= PROD_BITS'(u_ff[0] * w_ff[2]);
         p_ff[4] <= PROD_BITS'(u_ff[0] * w_ff[1]);
         p_ff[5] <= PROD_BITS'(u_ff[1] * w_ff[0]);

         last4_ff <= last3_ff;
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= CROSS_BITS'(p_ff[2*i]) - CROSS_BITS'(p_ff[2*i+1]);
         end

         last5_ff <= last4_ff;
         for (int i = 0; i < 3; i++) begin
            neg5_ff[i] <= n_ff[i][CROSS_BITS-1];
            mag5_ff[i] <= n_ff[i][CROSS_BITS-1] ? MAG_BITS'(-n_ff[i]) : MAG_BITS'(n_ff[i]);
         end

         last6_ff  <= last5_ff;
         neg6_ff   <= neg5_ff;
         degen6_ff <= or_mag == '0;
         shift6_ff <= shift_in;
         for (int i = 0; i < 3; i++) begin
            mag6_ff[i] <= mag5_ff[i];
         end

         last7_ff  <= last6_ff;
         neg7_ff   <= neg6_ff;
         degen7_ff <= degen6_ff;
         for (int i = 0; i < 3; i++) begin
            m7_ff[i] <= M_BITS'(mag6_ff[i] >> shift6_ff);
         end

         last8_ff  <= last7_ff;
         neg8_ff   <= neg7_ff;
         degen8_ff <= degen7_ff;
         m8_ff     <= m7_ff;
         for (int i = 0; i < 3; i++) begin
            sq8_ff[i] <= m7_ff[i] * m7_ff[i];
         end

         sum9_ff        <= SUM_BITS'(sq8_ff[0]) + SUM_BITS'(sq8_ff[1]) + SUM_BITS'(sq8_ff[2]);
         side9_ff.last  <= last8_ff;
         side9_ff.degen <= degen8_ff;
         side9_ff.neg   <= neg8_ff;
         side9_ff.m     <= m8_ff;
      end
   end

   tfn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (v9_ff),
      .in_rad    (sum9_ff),
      .in_side   (side9_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = (NUM_BITS'(sq_side.m[i]) << NORMAL_FRAC_BITS) + NUM_BITS'(sq_root >> 1);
      end
      dv_side_in.last  = sq_side.last;
      dv_side_in.degen = sq_side.degen;
      dv_side_in.neg   = sq_side.neg;
   end

   tfn_div u_div (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (sq_valid),
      .in_divisor (sq_root),
      .in_num     (num),
      .in_side    (dv_side_in),
      .out_valid  (dv_valid),
      .out_quo    (dv_quo),
      .out_side   (dv_side)
   );

   always_comb begin
      logic [31:0] qz;
      for (int i = 0; i < 3; i++) begin
         qz = 32'(dv_quo[i]);
         if (dv_side.degen) begin
            comp[i] = '0;
         end else if (dv_side.neg[i]) begin
            comp[i] = (qz > 32'(OUT_MIN_MAG)) ? OUT_BITS'(-OUT_MIN_MAG) : OUT_BITS'(-qz);
         end else begin
            comp[i] = (qz > 32'(OUT_MAX)) ? OUT_BITS'(OUT_MAX) : OUT_BITS'(qz);
         end
      end
      rsp_in.normal_x   = comp[0];
      rsp_in.normal_y   = comp[1];
      rsp_in.normal_z   = comp[2];
      rsp_in.degenerate = dv_side.degen;
      rsp_in.final_mark = dv_side.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_valid;
      end
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
endmodule

### src/tfn_checker.sv
// Port checker of the triangle face normal block and its bind
`timescale 1ns / 1ps
`include "triangle_face_normal_top_macros.svh"
module tfn_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [tfn_pkg::OUT_BITS-1:0] normal_x,
   input logic signed [tfn_pkg::OUT_BITS-1:0] normal_y,
   input logic signed [tfn_pkg::OUT_BITS-1:0] normal_z,
   input logic                               degenerate
);
   import tfn_pkg::*;

   `TFN_ASSERT_NOW(a_degen_zero, clock, reset, rsp_valid && degenerate, normal_x == '0 && normal_y == '0 && normal_z == '0, "degenerate word carries a nonzero normal")
   `TFN_ASSERT_NOW(a_unit_range, clock, reset, rsp_valid, normal_x >= -16384 && normal_x <= 16384 && normal_y >= -16384 && normal_y <= 16384 && normal_z >= -16384 && normal_z <= 16384, "normal component beyond unit range")
   `TFN_ASSERT_NOW(a_nonzero, clock, reset, rsp_valid && !degenerate, normal_x != '0 || normal_y != '0 || normal_z != '0, "proper face gave a zero normal")
   `TFN_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(degenerate), "stalled result word changed")
endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .normal_x   (rsp_chan.payload.normal_x),
   .normal_y   (rsp_chan.payload.normal_y),
   .normal_z   (rsp_chan.payload.normal_z),
   .degenerate (rsp_chan.payload.degenerate)
);

### tb/tfn_if.sv
// Channel interfaces for the testbench are shared with the block's source files
`timescale 1ns / 1ps

### tb/triangle_face_normal_checker.sv
// Normal predictor and result checker for the triangle face normal block
`timescale 1ns / 1ps
module triangle_face_normal_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input tfn_pkg::req_payload_type req_word,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input tfn_pkg::rsp_payload_type rsp_word,
   output int                      error_count,
   output int                      pending_count,
   output int                      face_count,
   output int                      degen_count
);
   import tfn_pkg::*;

   logic signed [COORD_BITS-1:0] store_x [VERTEX_DEPTH];
   logic signed [COORD_BITS-1:0] store_y [VERTEX_DEPTH];
   logic signed [COORD_BITS-1:0] store_z [VERTEX_DEPTH];
   rsp_payload_type expected_normals [$];

   initial begin
      error_count = 0;
      face_count = 0;
      degen_count = 0;
   end

   assign pending_count = expected_normals.size();

   function automatic logic [63:0] root_of(logic [63:0] s);
      logic [63:0] res;
      logic [63:0] bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > s) bits = bits >> 2;
      while (bits != 0) begin
         if (s >= res + bits) begin
            s = s - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function automatic rsp_payload_type face_normal(req_payload_type w);
      rsp_payload_type r;
      logic signed [63:0] a [3];
      logic signed [63:0] b [3];
      logic signed [63:0] c [3];
      logic signed [63:0] u [3];
      logic signed [63:0] v [3];
      logic signed [127:0] n [3];
      logic [127:0] mg [3];
      logic [63:0] m [3];
      logic [63:0] sum, len, q;
      logic signed [63:0] val [3];
      int width, shift;
      a[0] = store_x[w.corner_a]; a[1] = store_y[w.corner_a]; a[2] = store_z[w.corner_a];
      b[0] = store_x[w.corner_b]; b[1] = store_y[w.corner_b]; b[2] = store_z[w.corner_b];
      c[0] = store_x[w.corner_c]; c[1] = store_y[w.corner_c]; c[2] = store_z[w.corner_c];
      for (int i = 0; i < 3; i++) begin
         u[i] = b[i] - a[i];
         v[i] = c[i] - a[i];
      end
      n[0] = 128'(u[1]) * 128'(v[2]) - 128'(u[2]) * 128'(v[1]);
      n[1] = 128'(u[2]) * 128'(v[0]) - 128'(u[0]) * 128'(v[2]);
      n[2] = 128'(u[0]) * 128'(v[1]) - 128'(u[1]) * 128'(v[0]);
      r = '0;
      r.final_mark = w.last_face;
      width = 0;
      for (int i = 0; i < 3; i++) begin
         mg[i] = n[i] < 0 ? -n[i] : n[i];
         for (int k = 0; k < 128; k++) if (mg[i][k] && k + 1 > width) width = k + 1;
      end
      if (width == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      shift = width > 31 ? width - 31 : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = 64'(mg[i] >> shift);
         sum = sum + m[i] * m[i];
      end
      len = root_of(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
         if (n[i] < 0) val[i] = q > 32768 ? -64'sd32768 : -$signed(q);
         else val[i] = q > 32767 ? 64'sd32767 : $signed(q);
      end
      r.normal_x = val[0][15:0];
      r.normal_y = val[1][15:0];
      r.normal_z = val[2][15:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_word.mode == MODE_WRITE) begin
               store_x[req_word.vertex_index] <= req_word.coord_x;
               store_y[req_word.vertex_index] <= req_word.coord_y;
               store_z[req_word.vertex_index] <= req_word.coord_z;
            end else begin
               expected_normals.push_back(face_normal(req_word));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_normals.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = expected_normals.pop_front();
               face_count++;
               if (want.degenerate) degen_count++;
               if (rsp_word.normal_x !== want.normal_x)
                  report_mismatch("normal_x", rsp_word.normal_x, want.normal_x);
               if (rsp_word.normal_y !== want.normal_y)
                  report_mismatch("normal_y", rsp_word.normal_y, want.normal_y);
               if (rsp_word.normal_z !== want.normal_z)
                  report_mismatch("normal_z", rsp_word.normal_z, want.normal_z);
               if (rsp_word.degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_word.degenerate, want.degenerate);
               if (rsp_word.final_mark !== want.final_mark)
                  report_mismatch("final_mark", rsp_word.final_mark, want.final_mark);
            end
         end
      end
   end
endmodule

### tb/triangle_face_normal_top_test.sv
// Stimulus and verdict for the triangle face normal block
`timescale 1ns / 1ps
module triangle_face_normal_top_test;
   import tfn_pkg::*;

   localparam int LIMIT = 400000;
   localparam int VERTS = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   errors, pending, faces, degens;
   bit   calm = 1'b0;
   bit   written [VERTEX_DEPTH];
   logic [INDEX_BITS-1:0] known [$];

   tfn_req_if req_chan ();
   tfn_rsp_if rsp_chan ();

   triangle_face_normal_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   triangle_face_normal_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_word      (req_chan.payload),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_word      (rsp_chan.payload),
      .error_count   (errors),
      .pending_count (pending),
      .face_count    (faces),
      .degen_count   (degens)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[triangle_face_normal_top] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= calm || ($urandom_range(99) >= 11);
   end

   function automatic req_payload_type random_noise();
      req_payload_type w;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(req_payload_type)-1:0];
      return w;
   endfunction

   task automatic send(req_payload_type w);
      if (!calm) begin
         while ($urandom_range(99) < 11) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic put_vertex(logic [INDEX_BITS-1:0] idx, int x, int y, int z);
      req_payload_type w;
      w = random_noise();
      w.mode = MODE_WRITE;
      w.vertex_index = idx;
      w.coord_x = FIELD_BITS'(x);
      w.coord_y = FIELD_BITS'(y);
      w.coord_z = FIELD_BITS'(z);
      if (!written[idx]) known.push_back(idx);
      written[idx] = 1'b1;
      send(w);
   endtask

   task automatic put_face(logic [INDEX_BITS-1:0] a, logic [INDEX_BITS-1:0] b,
                           logic [INDEX_BITS-1:0] c, bit last);
      req_payload_type w;
      w = random_noise();
      w.mode = MODE_FACE;
      w.corner_a = a;
      w.corner_b = b;
      w.corner_c = c;
      w.last_face = last;
      send(w);
   endtask

   function automatic int random_coord();
      case ($urandom_range(3))
         0: return $urandom_range(1, 0) ? 524287 : -524288;
         1: return int'($urandom_range(200)) - 100;
         default: return int'($urandom_range(1048575)) - 524288;
      endcase
   endfunction

   initial begin
      int mx, mn;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      mx = 524287;
      mn = -524288;
      put_vertex(0, 0, 0, 0);
      put_vertex(1, 1024, 0, 0);
      put_vertex(2, 0, 1024, 0);
      put_vertex(4095, mx, mx, mx);
      put_vertex(4094, mn, mn, mn);
      put_vertex(3, mn, mx, 0);
      put_vertex(5, mx, mn, mx);
      put_vertex(6, mn, 0, mn);
      put_face(0, 1, 2, 1'b0);
      put_face(0, 2, 1, 1'b1);
      put_face(0, 0, 0, 1'b0);
      put_face(4095, 4094, 0, 1'b0);
      put_face(4094, 3, 5, 1'b1);
      put_face(4095, 6, 3, 1'b0);
      put_face(5, 6, 4094, 1'b0);
      put_vertex(7, 1, 0, 0);
      put_face(0, 7, 7, 1'b0);
      put_vertex(8, 0, 0, 1);
      put_face(0, 7, 8, 1'b1);
      put_face(3, 5, 6, 1'b0);

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      for (int i = 0; i < 1530; i++) begin
         calm = (i >= 600 && i < 800);
         if (i == 1000) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         if (known.size() < 3 || $urandom_range(99) < 30) begin
            put_vertex($urandom_range(99) < 85 ? INDEX_BITS'($urandom_range(VERTS - 1))
                                                 : INDEX_BITS'($urandom_range(VERTEX_DEPTH - 1)),
                       random_coord(), random_coord(), random_coord());
         end else begin
            logic [INDEX_BITS-1:0] a, b, c;
            a = known[$urandom_range(known.size() - 1)];
            b = known[$urandom_range(known.size() - 1)];
            c = $urandom_range(9) == 0 ? b : known[$urandom_range(known.size() - 1)];
            put_face(a, b, c, $urandom_range(7) == 0);
         end
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("covered %0d face normals, %0d of them degenerate, with vertex writes between",
               faces, degens);
      if (errors == 0) begin
         $display("[triangle_face_normal_top] OK");
      end else begin
         $display("[triangle_face_normal_top] ERROR");
      end
      $finish;
   end
endmodule

### files.f
+incdir+src
src/tfn_pkg.sv
src/tfn_if.sv
src/tfn_sqrt.sv
src/tfn_div.sv
src/triangle_face_normal_top.sv
src/tfn_checker.sv
tb/tfn_if.sv
tb/triangle_face_normal_checker.sv
tb/triangle_face_normal_top_test.sv
